FILE: rtl/core/bimodal_gshare_branch_predictor_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the branch predictor
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BIMODAL_GSHARE_BRANCH_PREDICTOR_TOP_DEFINES_SVH
`define BIMODAL_GSHARE_BRANCH_PREDICTOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BGBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("branch predictor check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BGBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("branch predictor check failed");

`endif

FILE: rtl/core/bgbp_pkg.sv
// ----------------------------------------------------------------------------
// Branch predictor package
// Sizes, register indexes, counter codes and helper types.
// ----------------------------------------------------------------------------
`default_nettype none

package bgbp_pkg;

    localparam int MAX_INDEX_BITS = 12;
    localparam int TABLE_DEPTH    = 1 << MAX_INDEX_BITS;
    localparam int IDX_W          = MAX_INDEX_BITS;
    localparam int ADDR_W         = 32;
    localparam int TOTAL_W        = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 4;
    localparam int CTR_W          = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE         = 2'd0,
        CFG_INDEX_BITS   = 2'd1,
        CFG_HISTORY_BITS = 2'd2
    } cfg_reg_t;

    localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN = 2'd2;
    localparam logic [CTR_W-1:0] CTR_MAX        = 2'd3;
    localparam logic [CTR_W-1:0] CTR_MIN        = 2'd0;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [CTR_W-1:0] data;
    } ram_wr_t;

    function automatic logic [IDX_W-1:0] low_mask(input logic [CFG_DATA_W-1:0] bits);
        logic [IDX_W:0] ones;
        ones = ({{IDX_W{1'b0}}, 1'b1} << bits) - {{IDX_W{1'b0}}, 1'b1};
        return ones[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bgbp_if.sv
// ----------------------------------------------------------------------------
// Branch predictor channels
// Branch input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgbp_branch_if;
    import bgbp_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] branch_address;
    logic              taken;
    modport source (output valid, branch_address, taken, input ready);
    modport sink (input valid, branch_address, taken, output ready);
endinterface

interface bgbp_result_if;
    import bgbp_pkg::*;
    logic               valid;
    logic               ready;
    logic               predicted_taken;
    logic               mispredicted;
    logic [IDX_W-1:0]   table_index;
    logic [TOTAL_W-1:0] prediction_total;
    logic [TOTAL_W-1:0] mispredict_total;
    modport source (output valid, predicted_taken, mispredicted, table_index,
                    prediction_total, mispredict_total, input ready);
    modport sink (input valid, predicted_taken, mispredicted, table_index,
                  prediction_total, mispredict_total, output ready);
endinterface

interface bgbp_cfg_if;
    import bgbp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bimodal_gshare_branch_predictor_top.sv
// Flow: an accepted item enters the s1 registers with its RAM read, then the output registers.
// Throughput: one item per cycle while results are taken; the counter read-modify-write spans
// the RAM read and the update, with one forwarding register for back-to-back hits.
// Reset: after rst_n rises, a clearing pass writes weakly taken into all 4096 table
// entries, one per cycle; branch.ready stays low until the pass is done.
// ----------------------------------------------------------------------------
// Branch predictor top level
// Bimodal or gshare two-bit counter predictor with running totals.
// ----------------------------------------------------------------------------
`default_nettype none

module bimodal_gshare_branch_predictor_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bgbp_branch_if.sink   branch,
    bgbp_result_if.source result,
    bgbp_cfg_if.sink      cfg
);
    import bgbp_pkg::*;

    logic             accept;
    logic             in_ready;
    logic [IDX_W-1:0] rd_idx;
    logic [CTR_W-1:0] rd_ctr;
    ram_wr_t          wr;

    assign branch.ready = in_ready;
    assign accept       = branch.valid && in_ready;

    bgbp_index u_index (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .accept         (accept),
        .branch_address (branch.branch_address),
        .taken          (branch.taken),
        .rd_idx         (rd_idx)
    );

    bgbp_ram #(
        .WIDTH (CTR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (accept),
        .raddr (rd_idx),
        .rdata (rd_ctr)
    );

    bgbp_update u_update (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rd_idx   (rd_idx),
        .taken    (branch.taken),
        .rd_ctr   (rd_ctr),
        .wr       (wr),
        .in_ready (in_ready),
        .result   (result)
    );

endmodule

`default_nettype wire

FILE: rtl/core/bgbp_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bgbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/bgbp_index.sv
// ----------------------------------------------------------------------------
// Branch predictor index unit
// Holds configuration and global history, forms the counter table index.
// ----------------------------------------------------------------------------
`default_nettype none

module bgbp_index (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    bgbp_cfg_if.sink                         cfg,
    input  wire logic                        accept,
    input  wire logic [bgbp_pkg::ADDR_W-1:0] branch_address,
    input  wire logic                        taken,
    output      logic [bgbp_pkg::IDX_W-1:0]  rd_idx
);
    import bgbp_pkg::*;

    logic                  mode_reg;
    logic [CFG_DATA_W-1:0] index_bits_reg;
    logic [CFG_DATA_W-1:0] history_bits_reg;
    logic [IDX_W-1:0]      history_reg;
    logic [IDX_W-1:0]      history_next;
    logic [CFG_DATA_W-1:0] m_eff;
    logic [CFG_DATA_W-1:0] n_eff;
    logic [IDX_W-1:0]      hist_part;
    logic [IDX_W-1:0]      hist_in;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= 1'b0;
            index_bits_reg   <= CFG_DATA_W'(MAX_INDEX_BITS);
            history_bits_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                CFG_MODE:         mode_reg         <= cfg.data[0];
                CFG_INDEX_BITS:   index_bits_reg   <= cfg.data;
                CFG_HISTORY_BITS: history_bits_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    // Out-of-range index widths clamp to the table; history never exceeds the index.
    always_comb
    begin
        if (index_bits_reg == '0)
            m_eff = CFG_DATA_W'(1);
        else if (index_bits_reg > CFG_DATA_W'(MAX_INDEX_BITS))
            m_eff = CFG_DATA_W'(MAX_INDEX_BITS);
        else
            m_eff = index_bits_reg;
        n_eff = (history_bits_reg > m_eff) ? m_eff : history_bits_reg;
    end

    always_comb
    begin
        hist_part = (history_reg & low_mask(n_eff)) << (m_eff - n_eff);
        rd_idx    = branch_address[IDX_W+1:2] & low_mask(m_eff);
        if (mode_reg)
            rd_idx = rd_idx ^ hist_part;
    end

    // The outcome enters at the top of the active history window.
    always_comb
    begin
        hist_in      = IDX_W'(taken) << (n_eff - CFG_DATA_W'(1));
        history_next = history_reg;
        if (accept && mode_reg && (n_eff != '0))
            history_next = ((history_reg & low_mask(n_eff)) >> 1) | hist_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            history_reg <= '0;
        else
            history_reg <= history_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/bgbp_update.sv
// ----------------------------------------------------------------------------
// Branch predictor update stage
// Counter read-modify-write with forwarding, totals, table clear, output item.
// ----------------------------------------------------------------------------
`default_nettype none

module bgbp_update (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [bgbp_pkg::IDX_W-1:0] rd_idx,
    input  wire logic                       taken,
    input  wire logic [bgbp_pkg::CTR_W-1:0] rd_ctr,
    output      bgbp_pkg::ram_wr_t          wr,
    output      logic                       in_ready,
    bgbp_result_if.source                   result
);
    import bgbp_pkg::*;

    logic               clr_active_reg;
    logic [IDX_W-1:0]   clr_addr_reg;
    logic               s1_valid_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_taken_reg;
    logic               fwd_valid_reg;
    logic [IDX_W-1:0]   fwd_idx_reg;
    logic [CTR_W-1:0]   fwd_ctr_reg;
    logic [TOTAL_W-1:0] pred_cnt_reg;
    logic [TOTAL_W-1:0] pred_cnt_next;
    logic [TOTAL_W-1:0] miss_cnt_reg;
    logic [TOTAL_W-1:0] miss_cnt_next;
    logic               out_valid_reg;
    logic               out_pred_reg;
    logic               out_miss_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic [TOTAL_W-1:0] out_pred_cnt_reg;
    logic [TOTAL_W-1:0] out_miss_cnt_reg;
    logic               s1_adv;
    logic [CTR_W-1:0]   ctr_cur;
    logic [CTR_W-1:0]   ctr_new;
    logic               pred;
    logic               miss;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || result.ready);
    assign in_ready = !clr_active_reg && (!s1_valid_reg || s1_adv);

    // The item ahead wrote back at the edge this item's read was taken, so the
    // RAM returned the old value: take the forwarded one instead.
    assign ctr_cur = (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg)) ? fwd_ctr_reg : rd_ctr;
    assign pred    = ctr_cur[1];
    assign miss    = pred ^ s1_taken_reg;

    always_comb
    begin
        ctr_new = ctr_cur;
        if (s1_taken_reg && (ctr_cur != CTR_MAX))
            ctr_new = ctr_cur + CTR_W'(1);
        else if (!s1_taken_reg && (ctr_cur != CTR_MIN))
            ctr_new = ctr_cur - CTR_W'(1);
    end

    always_comb
    begin
        pred_cnt_next = (pred_cnt_reg == '1) ? pred_cnt_reg : pred_cnt_reg + TOTAL_W'(1);
        miss_cnt_next = miss_cnt_reg;
        if (miss && (miss_cnt_reg != '1))
            miss_cnt_next = miss_cnt_reg + TOTAL_W'(1);
    end

    always_comb
    begin
        wr.en   = clr_active_reg || s1_adv;
        wr.addr = clr_active_reg ? clr_addr_reg : s1_idx_reg;
        wr.data = clr_active_reg ? CTR_WEAK_TAKEN : ctr_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            pred_cnt_reg   <= '0;
            miss_cnt_reg   <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == '1)
                    clr_active_reg <= 1'b0;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (accept || s1_adv)
                fwd_valid_reg <= s1_adv;
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                pred_cnt_reg  <= pred_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg   <= rd_idx;
            s1_taken_reg <= taken;
        end
        if (accept || s1_adv)
        begin
            fwd_idx_reg <= s1_idx_reg;
            fwd_ctr_reg <= ctr_new;
        end
        if (s1_adv)
        begin
            out_pred_reg     <= pred;
            out_miss_reg     <= miss;
            out_idx_reg      <= s1_idx_reg;
            out_pred_cnt_reg <= pred_cnt_next;
            out_miss_cnt_reg <= miss_cnt_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.predicted_taken  = out_pred_reg;
    assign result.mispredicted     = out_miss_reg;
    assign result.table_index      = out_idx_reg;
    assign result.prediction_total = out_pred_cnt_reg;
    assign result.mispredict_total = out_miss_cnt_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bgbp_checker.sv
// ----------------------------------------------------------------------------
// Branch predictor port checker
// Checks result items seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bimodal_gshare_branch_predictor_top_defines.svh"

module bgbp_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          mispredicted,
    input wire logic [bgbp_pkg::IDX_W-1:0]    table_index,
    input wire logic [bgbp_pkg::TOTAL_W-1:0]  prediction_total,
    input wire logic [bgbp_pkg::TOTAL_W-1:0]  mispredict_total
);
    import bgbp_pkg::*;

    // A stalled result item keeps its place and its prediction total.
    `BGBP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(table_index) && $stable(prediction_total))
    // Mispredictions can never outnumber predictions.
    `BGBP_ASSERT_NOW(a_order, clk, rst_n, out_valid, mispredict_total <= prediction_total)
    // Every result item counts itself.
    `BGBP_ASSERT_NOW(a_count, clk, rst_n, out_valid, prediction_total != '0)
    // A mispredicted item is included in the mispredict total.
    `BGBP_ASSERT_NOW(a_miss, clk, rst_n, out_valid && mispredicted, mispredict_total != '0)

endmodule

bind bimodal_gshare_branch_predictor_top bgbp_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .mispredicted     (result.mispredicted),
    .table_index      (result.table_index),
    .prediction_total (result.prediction_total),
    .mispredict_total (result.mispredict_total)
);

`default_nettype wire
